/* rtl/obbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbc_pkg
// Shared types and constants of the oriented box point test and closest point
// unit.
// ----------------------------------------------------------------------------
package obbc_pkg;

	localparam int REG_W     = 48;
	localparam int REG_IDX_W = 3;
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER  = 3'd0,
		REG_AXIS_R  = 3'd1,
		REG_AXIS_U  = 3'd2,
		REG_AXIS_F  = 3'd3,
		REG_EXTENTS = 3'd4
	} reg_idx_t;

	localparam logic [REG_W-1:0] CENTER_RST  = 48'd0;
	localparam logic [REG_W-1:0] AXIS_R_RST  = 48'h0000_0000_4000;
	localparam logic [REG_W-1:0] AXIS_U_RST  = 48'h0000_4000_0000;
	localparam logic [REG_W-1:0] AXIS_F_RST  = 48'h4000_0000_0000;
	localparam logic [REG_W-1:0] EXTENTS_RST = 48'd0;

	typedef struct packed {
		logic [REG_W-1:0]      center;
		logic [2:0][REG_W-1:0] axis;
		logic [REG_W-1:0]      extents;
	} cfg_t;

	typedef logic signed [DIFF_W-1:0] dval_t;
	typedef dval_t [2:0] diff_t;

	typedef struct packed {
		logic                      is_in;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} result_t;

endpackage

/* rtl/obb_point_test_and_closest_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_point_test_and_closest_unit
// Tests query points against one oriented bounding box and returns the
// inside flag and the closest point on the box.
// ----------------------------------------------------------------------------
// The box (center, three Q1.14 axes, three Q15.0 half extents) is set through
// the write port; the user must write it only while the unit is idle, as the
// unit does not enforce this. Points go in through push/full and results come
// out through empty/pop in order, one result per point. The unit takes one
// point per clock cycle and delivers one result per cycle as long as results
// are popped. An input stage and a four-stage arithmetic pipeline (projection
// multiply, clamp, rebuild multiply, round and saturate) are joined by a work
// queue, and an output queue holds finished results, so a stall on the result
// side backs up into the work queue before full rises.
// ----------------------------------------------------------------------------
module obb_point_test_and_closest_unit #(
	parameter int MID_DEPTH = obbc_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = obbc_pkg::OUT_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [obbc_pkg::REG_IDX_W-1:0]        wr_idx,
	input  logic [obbc_pkg::REG_W-1:0]            wr_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [obbc_pkg::COORD_W-1:0]   point_x,
	input  logic signed [obbc_pkg::COORD_W-1:0]   point_y,
	input  logic signed [obbc_pkg::COORD_W-1:0]   point_z,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  inside_res,
	output logic signed [obbc_pkg::COORD_W-1:0]   near_x,
	output logic signed [obbc_pkg::COORD_W-1:0]   near_y,
	output logic signed [obbc_pkg::COORD_W-1:0]   near_z
);
	import obbc_pkg::*;

	cfg_t    cfg_q;
	logic    mid_push;
	logic    mid_pop;
	logic    mid_full;
	logic    mid_empty;
	logic    mid_room;
	diff_t   mid_wdata;
	diff_t   mid_rdata;
	logic    out_push;
	logic    out_full;
	logic    out_room;
	result_t out_wdata;
	result_t out_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center  <= CENTER_RST;
			cfg_q.axis[0] <= AXIS_R_RST;
			cfg_q.axis[1] <= AXIS_U_RST;
			cfg_q.axis[2] <= AXIS_F_RST;
			cfg_q.extents <= EXTENTS_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_CENTER:  cfg_q.center  <= wr_data;
				REG_AXIS_R:  cfg_q.axis[0] <= wr_data;
				REG_AXIS_U:  cfg_q.axis[1] <= wr_data;
				REG_AXIS_F:  cfg_q.axis[2] <= wr_data;
				REG_EXTENTS: cfg_q.extents <= wr_data;
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	obbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.center   (cfg_q.center),
		.push     (push),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.full     (full),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_data (mid_wdata)
	);

	obbc_queue #(
		.WIDTH ($bits(diff_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty),
		.room   (mid_room)
	);

	obbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_room  (out_room),
		.out_push  (out_push),
		.out_data  (out_wdata)
	);

	obbc_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty),
		.room   (out_room)
	);

	assign inside_res = out_rdata.is_in && !(mid_room && out_full && !mid_room);
	assign near_x     = out_rdata.x;
	assign near_y     = out_rdata.y;
	assign near_z     = out_rdata.z;

endmodule

/* rtl/obbc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbc_queue
// Small first-in first-out queue with head shown combinationally; a push is
// taken on a full queue when a pop completes in the same cycle.
// ----------------------------------------------------------------------------
module obbc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty,
	output logic             room
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_fire;
	logic             pop_fire;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_fire  = pop && !empty;
	assign room      = !full || pop_fire;
	assign push_fire = push && room;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_fire, pop_fire})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/obbc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbc_front
// Input stage: takes a query point and registers its offset from the box
// center for the work queue.
// ----------------------------------------------------------------------------
module obbc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [obbc_pkg::REG_W-1:0]          center,
	input  logic                                push,
	input  logic signed [obbc_pkg::COORD_W-1:0] point_x,
	input  logic signed [obbc_pkg::COORD_W-1:0] point_y,
	input  logic signed [obbc_pkg::COORD_W-1:0] point_z,
	output logic                                full,
	input  logic                                mid_full,
	output logic                                mid_push,
	output obbc_pkg::diff_t                     mid_data
);
	import obbc_pkg::*;

	logic  v_s1;
	diff_t d_s1;
	logic  load;
	logic  drain;
	logic signed [COORD_W-1:0] pt [3];

	assign pt[0]    = point_x;
	assign pt[1]    = point_y;
	assign pt[2]    = point_z;
	assign drain    = v_s1 && !mid_full;
	assign full     = v_s1 && mid_full;
	assign load     = push && !full;
	assign mid_push = drain;
	assign mid_data = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= load || (v_s1 && !drain);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIFF_W'(pt[i]) - DIFF_W'($signed(center[COORD_W*i +: COORD_W]));
			end
		end
	end

endmodule

/* rtl/obbc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbc_back
// Execution pipeline: projects the offset onto the box axes, clamps against
// the half extents and rebuilds the rounded, saturated closest point.
// ----------------------------------------------------------------------------
module obbc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  obbc_pkg::cfg_t      cfg,
	input  logic                mid_empty,
	input  obbc_pkg::diff_t     mid_data,
	output logic                mid_pop,
	input  logic                out_room,
	output logic                out_push,
	output obbc_pkg::result_t   out_data
);
	import obbc_pkg::*;

	localparam int P1_W   = DIFF_W + COORD_W;
	localparam int PROJ_W = P1_W + 2;
	localparam int CL_W   = COORD_W + 14;
	localparam int P3_W   = COORD_W + CL_W;
	localparam int ACC_W  = 49;
	localparam int SH_W   = ACC_W - 28;

	logic signed [COORD_W-1:0] ax [3][3];
	logic signed [COORD_W-1:0] ctr [3];
	logic signed [PROJ_W-1:0]  lim [3];

	logic adv;
	logic take;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [P1_W-1:0]   prod_s1 [3][3];
	logic signed [PROJ_W-1:0] proj [3];
	logic signed [CL_W-1:0]   clamp_c [3];
	logic [2:0]               in_c;
	logic signed [CL_W-1:0]   clamp_s2 [3];
	logic                     inside_s2;
	logic signed [P3_W-1:0]   prod_s3 [3][3];
	logic                     inside_s3;
	logic signed [ACC_W-1:0]  acc [3];
	logic signed [SH_W-1:0]   sh [3];
	logic signed [COORD_W-1:0] sat [3];
	result_t                  res_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ctr[i] = $signed(cfg.center[COORD_W*i +: COORD_W]);
			lim[i] = cfg.extents[COORD_W*i + COORD_W - 1] ? '0 :
				PROJ_W'({cfg.extents[COORD_W*i +: COORD_W-1], 14'b0});
			for (int j = 0; j < 3; j++) begin
				ax[j][i] = $signed(cfg.axis[j][COORD_W*i +: COORD_W]);
			end
		end
	end

	assign adv      = !v_s4 || out_room;
	assign take     = adv && !mid_empty;
	assign mid_pop  = take;
	assign out_push = v_s4 && out_room;
	assign out_data = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// projection, clamp and range test
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			proj[j] = PROJ_W'(prod_s1[j][0]) + PROJ_W'(prod_s1[j][1]) +
				PROJ_W'(prod_s1[j][2]);
			if (proj[j] > lim[j]) begin
				clamp_c[j] = CL_W'(lim[j]);
				in_c[j]    = 1'b0;
			end else if (proj[j] < -lim[j]) begin
				clamp_c[j] = CL_W'(-lim[j]);
				in_c[j]    = 1'b0;
			end else begin
				clamp_c[j] = CL_W'(proj[j]);
				in_c[j]    = 1'b1;
			end
		end
	end

	// rebuild, round half up, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'($signed({ctr[i], 28'b0})) + ACC_W'(prod_s3[0][i]) +
				ACC_W'(prod_s3[1][i]) + ACC_W'(prod_s3[2][i]) + ACC_W'(1 << 27);
			sh[i]  = acc[i][ACC_W-1:28];
			if (sh[i] > SH_W'(32767)) begin
				sat[i] = 16'sh7FFF;
			end else if (sh[i] < -SH_W'(32768)) begin
				sat[i] = -16'sh8000;
			end else begin
				sat[i] = sh[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s1[j][i] <= $signed(mid_data[i]) * ax[j][i];
					prod_s3[j][i] <= ax[j][i] * clamp_s2[j];
				end
				clamp_s2[j] <= clamp_c[j];
			end
			inside_s2    <= &in_c;
			inside_s3    <= inside_s2;
			res_s4.is_in <= inside_s3;
			res_s4.x     <= sat[0];
			res_s4.y     <= sat[1];
			res_s4.z     <= sat[2];
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the oriented box point test and closest point unit.
// ----------------------------------------------------------------------------
// A table of directed points and register writes comes first: reset values,
// extreme coordinates, negative half extents, skewed and non-unit axes,
// saturation, rounding of halves and writes to unused indexes. Random phases
// follow, each with a fresh box written while the unit is idle, and mostly
// points near the box so that both inside and outside results show up.
// Each accepted point gets the expected result of its table row or of a
// bit-exact predictor, and every popped result is checked against the oldest
// prediction. The sender works in bursts and the receiver stalls on its own
// pattern, with one long hold-off that backs the unit up until full rises.
// ----------------------------------------------------------------------------
module testbench;
	import obbc_pkg::*;

	localparam int N_PHASES       = 8;
	localparam int PHASE_POINTS   = 50;
	localparam int HOLDOFF_PHASE  = 3;
	localparam int HOLDOFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;
	localparam int MAX_REPORTS    = 10;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [REG_W-1:0]     ALL_ONES  = {REG_W{1'b1}};
	localparam logic [REG_W-1:0]     EXT_MAX   = 48'h7FFF_7FFF_7FFF;
	localparam logic [REG_W-1:0]     EXT_NEG   = 48'h8000_8000_8000;

	typedef struct {
		bit                        is_write;
		logic [REG_IDX_W-1:0]      idx;
		logic [REG_W-1:0]          data;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		bit                        typed;
		result_t                   want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [REG_IDX_W-1:0]      wr_idx;
	logic [REG_W-1:0]          wr_data;
	logic                      push;
	logic                      full;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      empty;
	logic                      pop;
	logic                      inside_res;
	logic signed [COORD_W-1:0] near_x;
	logic signed [COORD_W-1:0] near_y;
	logic signed [COORD_W-1:0] near_z;

	cfg_t      box_cfg;
	result_t   pending_nearest[$];
	stim_row_t directed_rows[$];
	bit        row_typed;
	result_t   row_want;

	int mismatch_count;
	int points_taken;
	int results_taken;
	int inside_count;
	int saturated_count;
	int full_stall_cycles;
	int cfg_writes;
	int idle_cycles;
	int holdoff_reqs;
	int burst_left;
	bit no_gaps;

	obb_point_test_and_closest_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data),
		.push       (push),
		.full       (full),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.empty      (empty),
		.pop        (pop),
		.inside_res (inside_res),
		.near_x     (near_x),
		.near_y     (near_y),
		.near_z     (near_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint lane(logic [REG_W-1:0] word, int k);
		return longint'($signed(word[COORD_W*k +: COORD_W]));
	endfunction

	function automatic result_t closest_on_box(cfg_t box, logic [REG_W-1:0] pt);
		longint offs[3];
		longint acc[3];
		longint proj;
		longint lim;
		longint q;
		logic [COORD_W-1:0] rounded[3];
		result_t r;
		r.is_in = 1'b1;
		for (int i = 0; i < 3; i++) begin
			offs[i] = lane(pt, i) - lane(box.center, i);
			acc[i] = lane(box.center, i) <<< 28;
		end
		for (int j = 0; j < 3; j++) begin
			lim = lane(box.extents, j);
			if (lim < 0)
				lim = 0;
			lim = lim <<< 14;
			proj = 0;
			for (int i = 0; i < 3; i++)
				proj += offs[i] * lane(box.axis[j], i);
			if (proj > lim) begin
				proj = lim;
				r.is_in = 1'b0;
			end else if (proj < -lim) begin
				proj = -lim;
				r.is_in = 1'b0;
			end
			for (int i = 0; i < 3; i++)
				acc[i] += lane(box.axis[j], i) * proj;
		end
		for (int i = 0; i < 3; i++) begin
			q = (acc[i] + (longint'(1) <<< 27)) >>> 28;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			rounded[i] = q[COORD_W-1:0];
		end
		r.x = rounded[0];
		r.y = rounded[1];
		r.z = rounded[2];
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] spread(int span);
		return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic report_mismatch(string what, result_t want, result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected %0b (%0d,%0d,%0d), got %0b (%0d,%0d,%0d)",
				$time, what, want.is_in, want.x, want.y, want.z,
				got.is_in, got.x, got.y, got.z);
	endtask

	// predict on accept, check on pop, shadow the registers, watch for a hang
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			box_cfg.center  = CENTER_RST;
			box_cfg.axis[0] = AXIS_R_RST;
			box_cfg.axis[1] = AXIS_U_RST;
			box_cfg.axis[2] = AXIS_F_RST;
			box_cfg.extents = EXTENTS_RST;
			idle_cycles = 0;
		end else begin
			if (push && !full) begin
				want = row_typed ? row_want : closest_on_box(box_cfg, {point_z, point_y, point_x});
				pending_nearest.push_back(want);
				points_taken++;
				if (want.is_in)
					inside_count++;
				if (want.x == 16'sh7FFF || want.x == 16'sh8000 || want.y == 16'sh7FFF ||
						want.y == 16'sh8000 || want.z == 16'sh7FFF || want.z == 16'sh8000)
					saturated_count++;
			end
			if (push && full)
				full_stall_cycles++;
			if (pop && !empty) begin
				got.is_in = inside_res;
				got.x = near_x;
				got.y = near_y;
				got.z = near_z;
				results_taken++;
				if (pending_nearest.size() == 0) begin
					report_mismatch("result with nothing expected", '0, got);
				end else begin
					want = pending_nearest.pop_front();
					if (got.is_in !== want.is_in || got.x !== want.x ||
							got.y !== want.y || got.z !== want.z)
						report_mismatch($sformatf("result %0d", results_taken), want, got);
				end
			end
			if (wr_en) begin
				cfg_writes++;
				case (wr_idx)
					REG_CENTER:  box_cfg.center  = wr_data;
					REG_AXIS_R:  box_cfg.axis[0] = wr_data;
					REG_AXIS_U:  box_cfg.axis[1] = wr_data;
					REG_AXIS_F:  box_cfg.axis[2] = wr_data;
					REG_EXTENTS: box_cfg.extents = wr_data;
					default: ;
				endcase
			end
			if ((push && !full) || (pop && !empty) || wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					idle_cycles, pending_nearest.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: rotate a stall pattern, hold off for a long stretch on request
	initial begin
		int holdoff_seen;
		int holdoff_left;
		int pattern_age;
		logic [7:0] stall_pattern;
		holdoff_seen = 0;
		holdoff_left = 0;
		pattern_age = 0;
		stall_pattern = 8'hFF;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_reqs != holdoff_seen) begin
				holdoff_seen = holdoff_reqs;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				pop <= 1'b0;
			end else begin
				if (pattern_age == 0) begin
					pattern_age = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0: stall_pattern = 8'hFF;
						1: stall_pattern = 8'($urandom) | 8'h08;
						2: stall_pattern = 8'h55;
						default: stall_pattern = 8'h01;
					endcase
				end
				pattern_age--;
				pop <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
			end
		end
	end

	task automatic add_write(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		stim_row_t row;
		row = '{is_write: 1'b1, idx: idx, data: data, default: '0};
		directed_rows.push_back(row);
	endtask

	task automatic add_point(logic [COORD_W-1:0] px, py, pz);
		stim_row_t row;
		row = '{px: px, py: py, pz: pz, default: '0};
		directed_rows.push_back(row);
	endtask

	task automatic add_known(logic [COORD_W-1:0] px, py, pz, bit in_box,
			logic [COORD_W-1:0] nx, ny, nz);
		stim_row_t row;
		row = '{px: px, py: py, pz: pz, typed: 1'b1, default: '0};
		row.want.is_in = in_box;
		row.want.x = nx;
		row.want.y = ny;
		row.want.z = nz;
		directed_rows.push_back(row);
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_nearest.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_point(logic [COORD_W-1:0] px, py, pz, bit typed, result_t want);
		@(negedge clk);
		push <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (full);
	endtask

	task automatic idle_between();
		int gap;
		if (no_gaps)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
			point_x <= COORD_W'($urandom);
			point_y <= COORD_W'($urandom);
			point_z <= COORD_W'($urandom);
		end
	endtask

	initial begin
		logic [COORD_W-1:0] c[3];
		logic [REG_W-1:0] v;
		int sel;
		int reach;
		int style;
		int rot;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = REG_CENTER;
		wr_data = '0;
		push = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		row_typed = 1'b0;
		row_want = '0;
		holdoff_reqs = 0;
		burst_left = 0;
		no_gaps = 1'b0;

		add_known(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
		add_known(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		add_known(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		add_write(REG_EXTENTS, EXT_MAX);
		add_known(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_known(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h8001, 16'h8001, 16'h8001);
		add_known(16'h5555, 16'hAAAA, 16'h00FF, 1'b1, 16'h5555, 16'hAAAA, 16'h00FF);
		// sign bit set in a half extent: the axis collapses to zero width
		add_write(REG_EXTENTS, EXT_NEG);
		add_known(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
		add_known(16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		add_known(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		add_write(REG_SPARE, ALL_ONES);
		add_known(16'h0000, 16'h0000, 16'h0001, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		// skewed axes push the rebuilt point past the coordinate range
		add_write(REG_CENTER, 48'h7FFF_8000_0100);
		add_write(REG_EXTENTS, 48'h0100_0100_0100);
		add_write(REG_AXIS_R, 48'h4000_0000_4000);
		add_write(REG_AXIS_U, 48'h0000_4000_C000);
		add_point(16'h7FFF, 16'h0000, 16'h7FFF);
		add_point(16'h8000, 16'h8000, 16'h0000);
		add_point(16'h0100, 16'h8000, 16'h7FFF);
		add_write(REG_AXIS_F, EXT_NEG);
		add_write(REG_AXIS_R, EXT_MAX);
		add_point(16'h8000, 16'h7FFF, 16'h8000);
		add_point(16'h0000, 16'h0000, 16'h0000);
		add_write(REG_EXTENTS, ALL_ONES);
		add_write(REG_CENTER, ALL_ONES);
		add_write(REG_AXIS_R, ALL_ONES);
		add_write(REG_AXIS_U, ALL_ONES);
		add_write(REG_AXIS_F, ALL_ONES);
		add_point(16'h000C, 16'hFFF9, 16'h0003);
		add_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// half-scale axis: exact halves round up
		add_write(REG_CENTER, CENTER_RST);
		add_write(REG_AXIS_R, 48'h0000_0000_2000);
		add_write(REG_AXIS_U, AXIS_U_RST);
		add_write(REG_AXIS_F, AXIS_F_RST);
		add_write(REG_EXTENTS, EXT_MAX);
		add_known(16'h0002, 16'h0000, 16'h0000, 1'b1, 16'h0001, 16'h0000, 16'h0000);
		add_known(16'hFFFE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
		add_point(16'h0003, 16'h0000, 16'h0000);

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_write) begin
				settle();
				write_reg(directed_rows[r].idx, directed_rows[r].data);
			end else begin
				idle_between();
				send_point(directed_rows[r].px, directed_rows[r].py, directed_rows[r].pz,
					directed_rows[r].typed, directed_rows[r].want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			if (ph == 0 || ph == N_PHASES - 1) begin
				v = (ph == 0) ? '0 : ALL_ONES;
				write_reg(REG_CENTER, v);
				write_reg(REG_AXIS_R, v);
				write_reg(REG_AXIS_U, v);
				write_reg(REG_AXIS_F, v);
				write_reg(REG_EXTENTS, v);
			end else begin
				if ($urandom_range(0, 2) == 0)
					v = REG_W'({$urandom, $urandom});
				else
					v = {spread(2048), spread(2048), spread(2048)};
				write_reg(REG_CENTER, v);
				style = $urandom_range(0, 3);
				rot = $urandom_range(0, 2);
				for (int k = 0; k < 3; k++) begin
					v = '0;
					if (style <= 1)
						v[COORD_W*((k + rot) % 3) +: COORD_W] =
							$urandom_range(0, 1) ? 16'h4000 : 16'hC000;
					else if (style == 2)
						v = REG_W'({$urandom, $urandom});
					else
						v = {spread(16384), spread(16384), spread(16384)};
					write_reg(REG_IDX_W'(REG_AXIS_R + k), v);
				end
				if ($urandom_range(0, 3) == 0)
					v = REG_W'({$urandom, $urandom});
				else
					v = {16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
						16'($urandom_range(0, 4096))};
				write_reg(REG_EXTENTS, v);
				if ($urandom_range(0, 2) == 0)
					write_reg(REG_IDX_W'(REG_SPARE + $urandom_range(0, 2)),
						REG_W'({$urandom, $urandom}));
			end

			reach = 32;
			for (int k = 0; k < 3; k++)
				if (int'(lane(box_cfg.extents, k)) + 32 > reach)
					reach = int'(lane(box_cfg.extents, k)) + 32;
			if (reach > 16384)
				reach = 16384;

			if (ph == HOLDOFF_PHASE) begin
				holdoff_reqs++;
				no_gaps = 1'b1;
			end
			for (int n = 0; n < PHASE_POINTS; n++) begin
				idle_between();
				sel = $urandom_range(0, 9);
				for (int k = 0; k < 3; k++) begin
					if (sel < 6)
						c[k] = box_cfg.center[COORD_W*k +: COORD_W] + spread(reach);
					else if (sel == 6)
						case ($urandom_range(0, 2))
							0: c[k] = 16'h7FFF;
							1: c[k] = 16'h8000;
							default: c[k] = 16'h0000;
						endcase
					else
						c[k] = COORD_W'($urandom);
				end
				send_point(c[0], c[1], c[2], 1'b0, '0);
			end
			no_gaps = 1'b0;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d points (%0d inside, %0d saturated) over %0d register writes.",
			points_taken, inside_count, saturated_count, cfg_writes);
		$display("Input held off by full on %0d cycles; %0d results checked, %0d wrong.",
			full_stall_cycles, results_taken, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
